// ----- rtl/vic_pkg.sv -----
// ---------------------------------------------------------------------------
// vic_pkg: shared types and constants for the varint codec
// Request and response payload structs, result kinds and LEB128 constants.
// ---------------------------------------------------------------------------
package vic_pkg;

   // decoder length limit in bytes
   localparam int unsigned MAX_BYTES = 10;
   // longest encoded form of a 64-bit value
   localparam int unsigned ENC_BYTES = 10;
   // width of the byte counters
   localparam int unsigned CNT_W = 4;

   // continuation flag and payload mask of one encoded byte
   localparam logic [7:0] CONT_BIT     = 8'h80;
   localparam logic [7:0] PAYLOAD_MASK = 8'h7f;
   // bits in one group
   localparam int unsigned GROUP_W = 7;

   // request mode codes
   localparam logic MODE_ENCODE = 1'b0;
   localparam logic MODE_DECODE = 1'b1;

   // response kinds
   typedef enum logic [1:0] {
      KIND_BYTE  = 2'd0,
      KIND_VALUE = 2'd1,
      KIND_ERROR = 2'd2
   } kind_type;

   typedef struct packed {
      logic        mode;
      logic [63:0] value;
      logic [7:0]  in_byte;
   } req_type;

   typedef struct packed {
      kind_type    kind;
      logic [7:0]  out_byte;
      logic [63:0] out_value;
      logic        last;
   } rsp_type;

   // decoder verdict on one byte
   typedef struct packed {
      logic        valid;
      kind_type    kind;
      logic [63:0] value;
   } dec_out_type;

endpackage

// ----- rtl/vic_decoder.sv -----
// ---------------------------------------------------------------------------
// vic_decoder: LEB128 byte gatherer
// Holds the accumulator and byte count, merges one byte per strobe through
// a single group shifter and reports a finished value or an overlong error.
// ---------------------------------------------------------------------------
module vic_decoder import vic_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             byte_strobe,
   input  logic [7:0]       in_byte,
   output dec_out_type      dec_out
);

   logic [63:0]      acc_ff, acc_in;
   logic [CNT_W-1:0] count_ff, count_in;

   logic [6:0]  shift_full;
   logic [5:0]  shift_amt;
   logic [63:0] merged;
   logic        is_final;
   logic        at_limit;

   // group placement: bit 7 * count, count stays below the limit
   assign shift_full = 7'({3'b000, count_ff} * 7'(GROUP_W));
   assign shift_amt  = shift_full[5:0];
   assign merged     = acc_ff | (64'(in_byte & PAYLOAD_MASK) << shift_amt);

   assign is_final = ((in_byte & CONT_BIT) == 8'h00);
   assign at_limit = (({1'b0, count_ff} + 5'd1) >= 5'(MAX_BYTES));

   // verdict and next state
   always_comb begin
      acc_in        = acc_ff;
      count_in      = count_ff;
      dec_out.valid = 1'b0;
      dec_out.kind  = KIND_VALUE;
      dec_out.value = merged;
      if (byte_strobe) begin
         if (is_final) begin
            dec_out.valid = 1'b1;
            acc_in        = '0;
            count_in      = '0;
         end else if (at_limit) begin
            dec_out.valid = 1'b1;
            dec_out.kind  = KIND_ERROR;
            dec_out.value = '0;
            acc_in        = '0;
            count_in      = '0;
         end else begin
            acc_in   = merged;
            count_in = count_ff + CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff   <= '0;
         count_ff <= '0;
      end else begin
         acc_ff   <= acc_in;
         count_ff <= count_in;
      end
   end

endmodule

// ----- rtl/varint_codec.sv -----
// ---------------------------------------------------------------------------
// varint_codec: unsigned 64-bit LEB128 encoder and decoder
// Encode splits a value into 7-bit groups, one byte per cycle while responses
// are taken; decode gathers one byte per request into a 64-bit accumulator.
// ---------------------------------------------------------------------------
//  channel   ports                          direction  payload
//  request   req_valid req_ready req_data   in         req_type
//  response  rsp_valid rsp_ready rsp_data   out        rsp_type
//
//  Encode of a value needing k bytes (1..10) runs from accept to the next
//  accept as a load, then one byte per step through the group shift register,
//  then a drain of the response register. Decode takes continuation bytes
//  without a response; a result blocks requests until it drains.
//  Reset (synchronous) clears the sequencer, response valid flag and decoder.
//  A stalled response holds the shift register; requests wait meanwhile.
// ---------------------------------------------------------------------------
module varint_codec import vic_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   typedef enum logic [1:0] {
      ST_IDLE   = 2'b01,
      ST_ENCODE = 2'b10
   } state_type;

   state_type        state_ff, state_in;
   logic [63:0]      word_ff, word_in;
   logic [CNT_W-1:0] enc_count_ff, enc_count_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_data_ff, rsp_data_in;

   logic        req_accept;
   logic        slot_free;
   logic        dec_strobe;
   logic        enc_cont;
   dec_out_type dec_out;

   assign req_ready  = (state_ff == ST_IDLE) && !rsp_valid_ff;
   assign req_accept = req_valid && req_ready;
   assign slot_free  = !rsp_valid_ff || rsp_ready;
   assign dec_strobe = req_accept && (req_data.mode == MODE_DECODE);

   // more groups follow while high bits remain and the length cap allows
   assign enc_cont = (|word_ff[63:GROUP_W]) &&
                     (enc_count_ff < CNT_W'(ENC_BYTES - 1));

   vic_decoder u_decoder (
      .clock       (clock),
      .reset       (reset),
      .byte_strobe (dec_strobe),
      .in_byte     (req_data.in_byte),
      .dec_out     (dec_out)
   );

   // sequencer and response register
   always_comb begin
      state_in     = state_ff;
      word_in      = word_ff;
      enc_count_in = enc_count_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               if (req_data.mode == MODE_ENCODE) begin
                  word_in      = req_data.value;
                  enc_count_in = '0;
                  state_in     = ST_ENCODE;
               end else if (dec_out.valid) begin
                  rsp_valid_in          = 1'b1;
                  rsp_data_in.kind      = dec_out.kind;
                  rsp_data_in.out_byte  = '0;
                  rsp_data_in.out_value = dec_out.value;
                  rsp_data_in.last      = 1'b1;
               end
            end
         end
         ST_ENCODE: begin
            if (slot_free) begin
               rsp_valid_in          = 1'b1;
               rsp_data_in.kind      = KIND_BYTE;
               rsp_data_in.out_value = '0;
               if (enc_cont) begin
                  rsp_data_in.out_byte = (word_ff[7:0] & PAYLOAD_MASK) | CONT_BIT;
                  rsp_data_in.last     = 1'b0;
                  word_in              = word_ff >> GROUP_W;
                  enc_count_in         = enc_count_ff + CNT_W'(1);
               end else begin
                  rsp_data_in.out_byte = word_ff[7:0];
                  rsp_data_in.last     = 1'b1;
                  state_in             = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         enc_count_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         enc_count_ff <= enc_count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      word_ff     <= word_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ----- bench/tb_top.sv -----
// ---------------------------------------------------------------------------
// tb_top: self-checking bench for the varint codec
// Encode and decode requests go through a backlog queue to a clocked driver.
// Each accepted request updates a local LEB128 model that queues the owed
// responses. A clocked monitor checks every accepted response, field by field.
// ---------------------------------------------------------------------------
module tb_top import vic_pkg::*; ();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned ITEMS_TARGET = 410;
   localparam int unsigned TAIL_ITEMS   = 60;
   localparam int unsigned IDLE_LIMIT   = 1000;
   localparam int unsigned DRAIN_CYCLES = 30;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   // stimulus and expectation stores
   req_type     req_backlog_q[$];
   rsp_type     owed_rsp_q[$];

   // local copy of the decoder state
   logic [63:0] dec_accum = '0;
   int unsigned dec_len = 0;

   // handshake and pacing state
   logic        req_taken = 1'b0;
   logic        idle_ok = 1'b0;
   int unsigned gap_left = 0;
   int unsigned stall_left = 0;
   int unsigned quiet_left = 0;
   int unsigned idle_cycles = 0;

   // bookkeeping
   int unsigned n_items = 0;
   int unsigned n_enc = 0;
   int unsigned n_dec = 0;
   int unsigned n_accepted = 0;
   int unsigned n_bytes_seen = 0;
   int unsigned n_values_seen = 0;
   int unsigned n_errors_seen = 0;
   int unsigned fails = 0;

   varint_codec u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   // clock and reset
   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
   end

   function automatic rsp_type make_rsp(kind_type k, logic [7:0] b, logic [63:0] v,
                                        logic l);
      rsp_type r;
      r.kind      = k;
      r.out_byte  = b;
      r.out_value = v;
      r.last      = l;
      return r;
   endfunction

   // LEB128 behavior: queue the responses one accepted request owes
   function automatic void leb128_outcome(req_type r);
      logic [63:0] v;
      logic [7:0]  b;
      int unsigned n;
      int unsigned sh;
      if (r.mode == MODE_ENCODE) begin
         v = r.value;
         n = 0;
         while (v >= 64'(CONT_BIT) && n < ENC_BYTES - 1) begin
            owed_rsp_q.push_back(make_rsp(KIND_BYTE, (v[7:0] & PAYLOAD_MASK) | CONT_BIT,
                                          '0, 1'b0));
            v = v >> GROUP_W;
            n++;
         end
         owed_rsp_q.push_back(make_rsp(KIND_BYTE, v[7:0], '0, 1'b1));
      end else begin
         b  = r.in_byte;
         sh = GROUP_W * dec_len;
         // payload bits above bit 63 fall off
         if (sh < 64) dec_accum = dec_accum | (64'(b & PAYLOAD_MASK) << sh);
         if ((b & CONT_BIT) == 0) begin
            owed_rsp_q.push_back(make_rsp(KIND_VALUE, '0, dec_accum, 1'b1));
            dec_accum = '0;
            dec_len   = 0;
         end else if (dec_len + 1 >= MAX_BYTES) begin
            // overlong varint
            owed_rsp_q.push_back(make_rsp(KIND_ERROR, '0, '0, 1'b1));
            dec_accum = '0;
            dec_len   = 0;
         end else begin
            dec_len = dec_len + 1;
         end
      end
   endfunction

   // stimulus helpers: the unused field always carries noise
   task automatic push_encode(input logic [63:0] v);
      req_type r;
      r.mode    = MODE_ENCODE;
      r.value   = v;
      r.in_byte = 8'($urandom);
      req_backlog_q.push_back(r);
      n_items++;
      n_enc++;
   endtask

   task automatic push_decode(input logic [7:0] b);
      req_type r;
      r.mode    = MODE_DECODE;
      r.value   = {$urandom, $urandom};
      r.in_byte = b;
      req_backlog_q.push_back(r);
      n_items++;
      n_dec++;
   endtask

   // random value of random significant width
   function automatic logic [63:0] rand_value();
      int unsigned w;
      logic [63:0] v;
      w = $urandom_range(0, 64);
      v = {$urandom, $urandom};
      if (w < 64) v = v & ((64'd1 << w) - 64'd1);
      return v;
   endfunction

   // request driver
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         gap_left  <= 0;
         idle_ok   <= 1'b0;
      end else begin
         idle_ok <= (req_backlog_q.size() > TAIL_ITEMS) && (quiet_left == 0);
         if (!req_valid || req_taken) begin
            if (gap_left > 0) begin
               gap_left  <= gap_left - 1;
               req_valid <= 1'b0;
            end else if (req_backlog_q.size() == 0) begin
               req_valid <= 1'b0;
            end else if (idle_ok && $urandom_range(0, 3) == 0) begin
               gap_left  <= $urandom_range(1, 5) - 1;
               req_valid <= 1'b0;
            end else begin
               req_data  <= req_backlog_q.pop_front();
               req_valid <= 1'b1;
               // now and then a stretch with no idling at all
               if (quiet_left > 0) quiet_left <= quiet_left - 1;
               else if ($urandom_range(0, 24) == 0) quiet_left <= $urandom_range(10, 30);
            end
         end
      end
   end

   // response back-pressure
   always @(negedge clock) begin
      if (reset) begin
         rsp_ready  <= 1'b0;
         stall_left <= 0;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_ready  <= 1'b0;
      end else if (idle_ok && $urandom_range(0, 3) == 0) begin
         stall_left <= $urandom_range(1, 5) - 1;
         rsp_ready  <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // monitor: predict on request, check on response
   always @(posedge clock) begin
      rsp_type want;
      rsp_type got;
      req_taken <= req_valid && req_ready;
      if (reset) begin
         idle_cycles <= 0;
      end else begin
         if (req_valid && req_ready) begin
            leb128_outcome(req_data);
            n_accepted <= n_accepted + 1;
         end
         if (rsp_valid && rsp_ready) begin
            got = rsp_data;
            case (got.kind)
               KIND_BYTE:  n_bytes_seen++;
               KIND_VALUE: n_values_seen++;
               default:    n_errors_seen++;
            endcase
            if (owed_rsp_q.size() == 0) begin
               $error("response with nothing owed: kind %0d byte %h value %h last %0d",
                      got.kind, got.out_byte, got.out_value, got.last);
               fails++;
            end else begin
               want = owed_rsp_q.pop_front();
               if (got.kind !== want.kind) begin
                  $error("kind: expected %0d, got %0d", want.kind, got.kind);
                  fails++;
               end
               if (got.out_byte !== want.out_byte) begin
                  $error("out_byte: expected %h, got %h", want.out_byte, got.out_byte);
                  fails++;
               end
               if (got.out_value !== want.out_value) begin
                  $error("out_value: expected %h, got %h", want.out_value, got.out_value);
                  fails++;
               end
               if (got.last !== want.last) begin
                  $error("last: expected %0d, got %0d", want.last, got.last);
                  fails++;
               end
            end
         end
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles <= 0;
         else idle_cycles <= idle_cycles + 1;
      end
   end

   // watchdog on handshake silence
   initial begin
      while (idle_cycles < IDLE_LIMIT) @(negedge clock);
      $display("watchdog: no handshake for %0d cycles", IDLE_LIMIT);
      $display("== FAIL ==");
      $finish;
   end

   // stimulus and end of run
   initial begin
      int unsigned sel;
      int unsigned len;
      // group boundaries and extremes of the encoder
      push_encode(64'h0);
      push_encode(64'h7f);
      push_encode(64'h80);
      push_encode(64'h3fff);
      push_encode(64'h4000);
      push_encode(64'h20_0000);
      push_encode(64'h1000_0000);
      push_encode(64'h8000_0000_0000_0000);
      push_encode(64'hffff_ffff_ffff_ffff);
      // single byte zero, then an encode inside an open varint
      push_decode(8'h00);
      push_decode(8'hff);
      push_encode(64'h4000_1234);
      push_decode(8'h7f);
      // overlong varint
      for (int i = 0; i < MAX_BYTES; i++) push_decode(CONT_BIT | 8'(i));

      // random part: mostly well-formed varints, some overlong and some noise
      while (n_items < ITEMS_TARGET) begin
         sel = $urandom_range(0, 99);
         if (sel < 35) begin
            push_encode(rand_value());
         end else if (sel < 75) begin
            len = $urandom_range(1, MAX_BYTES);
            for (int i = 0; i < len; i++) begin
               if (i > 0 && $urandom_range(0, 6) == 0) push_encode(rand_value());
               push_decode((8'($urandom) & PAYLOAD_MASK) | ((i < len - 1) ? CONT_BIT : 8'h00));
            end
         end else if (sel < 85) begin
            for (int i = 0; i < MAX_BYTES; i++) push_decode(8'($urandom) | CONT_BIT);
         end else begin
            len = $urandom_range(1, 4);
            for (int i = 0; i < len; i++) push_decode(8'($urandom));
         end
      end

      // drain
      while (n_accepted < n_items) @(negedge clock);
      while (owed_rsp_q.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);

      $display("run: %0d encode and %0d decode requests accepted", n_enc, n_dec);
      $display("checked %0d encoded bytes, %0d decoded values, %0d malformed varints",
               n_bytes_seen, n_values_seen, n_errors_seen);
      if (fails == 0 && owed_rsp_q.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

// ----- files.f -----
rtl/vic_pkg.sv
rtl/vic_decoder.sv
rtl/varint_codec.sv
bench/tb_top.sv
